@@ hw/rtl/c6502_pkg.sv @@
`timescale 1ns / 1ps
package c6502_pkg;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_EXEC  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      MODE_IMP, MODE_IMM, MODE_ZP, MODE_ZPX, MODE_ZPY,
      MODE_ABS, MODE_ABX, MODE_ABY, MODE_INX, MODE_INY
   } mode_type;

   typedef enum logic [4:0] {
      K_NOP, K_LDA, K_LDX, K_LDY, K_STA, K_STX, K_STY, K_ADC, K_INC, K_DEC,
      K_TAX, K_TAY, K_TXA, K_TYA, K_TXS, K_TSX, K_PHA,
      K_INX, K_INY, K_DEX, K_DEY, K_CLC, K_CLI, K_CLV, K_SEC, K_SEI
   } kind_type;

   typedef struct packed {
      kind_type kind;
      mode_type mode;
   } decode_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_ACCESS, S_OP, S_O1, S_O2, S_P1, S_P2,
      S_DATA, S_WRITE, S_HALTCHK, S_DONE
   } state_type;

   // alu operation selects
   typedef enum logic [2:0] {
      ALU_PASS, ALU_ADC, ALU_INC, ALU_DEC, ALU_ADD
   } alu_op_type;

   localparam logic [7:0] HALT_BYTE = 8'hFF;
   localparam logic [7:0] STACK_PAGE = 8'h01;
   localparam logic [7:0] SP_RESET = 8'hFF;

   function automatic decode_type decode(input logic [7:0] op);
      decode_type d;
      d = '{kind: K_NOP, mode: MODE_IMP};
      unique case (op)
         8'hA9: d = '{K_LDA, MODE_IMM};
         8'hA5: d = '{K_LDA, MODE_ZP};
         8'hB5: d = '{K_LDA, MODE_ZPX};
         8'hAD: d = '{K_LDA, MODE_ABS};
         8'hBD: d = '{K_LDA, MODE_ABX};
         8'hB9: d = '{K_LDA, MODE_ABY};
         8'hA1: d = '{K_LDA, MODE_INX};
         8'hB1: d = '{K_LDA, MODE_INY};
         8'hA2: d = '{K_LDX, MODE_IMM};
         8'hA6: d = '{K_LDX, MODE_ZP};
         8'hB6: d = '{K_LDX, MODE_ZPY};
         8'hAE: d = '{K_LDX, MODE_ABS};
         8'hBE: d = '{K_LDX, MODE_ABY};
         8'hA0: d = '{K_LDY, MODE_IMM};
         8'hA4: d = '{K_LDY, MODE_ZP};
         8'hB4: d = '{K_LDY, MODE_ZPX};
         8'hAC: d = '{K_LDY, MODE_ABS};
         8'hBC: d = '{K_LDY, MODE_ABX};
         8'h85: d = '{K_STA, MODE_ZP};
         8'h95: d = '{K_STA, MODE_ZPX};
         8'h8D: d = '{K_STA, MODE_ABS};
         8'h9D: d = '{K_STA, MODE_ABX};
         8'h99: d = '{K_STA, MODE_ABY};
         8'h81: d = '{K_STA, MODE_INX};
         8'h91: d = '{K_STA, MODE_INY};
         8'h86: d = '{K_STX, MODE_ZP};
         8'h96: d = '{K_STX, MODE_ZPY};
         8'h8E: d = '{K_STX, MODE_ABS};
         8'h84: d = '{K_STY, MODE_ZP};
         8'h94: d = '{K_STY, MODE_ZPX};
         8'h8C: d = '{K_STY, MODE_ABS};
         8'h69: d = '{K_ADC, MODE_IMM};
         8'h65: d = '{K_ADC, MODE_ZP};
         8'h75: d = '{K_ADC, MODE_ZPX};
         8'h6D: d = '{K_ADC, MODE_ABS};
         8'h7D: d = '{K_ADC, MODE_ABX};
         8'h79: d = '{K_ADC, MODE_ABY};
         8'h61: d = '{K_ADC, MODE_INX};
         8'h71: d = '{K_ADC, MODE_INY};
         8'hE6: d = '{K_INC, MODE_ZP};
         8'hF6: d = '{K_INC, MODE_ZPX};
         8'hEE: d = '{K_INC, MODE_ABS};
         8'hFE: d = '{K_INC, MODE_ABX};
         8'hDE: d = '{K_DEC, MODE_ABX};
         8'hAA: d = '{K_TAX, MODE_IMP};
         8'hA8: d = '{K_TAY, MODE_IMP};
         8'h8A: d = '{K_TXA, MODE_IMP};
         8'h98: d = '{K_TYA, MODE_IMP};
         8'h9A: d = '{K_TXS, MODE_IMP};
         8'hBA: d = '{K_TSX, MODE_IMP};
         8'h48: d = '{K_PHA, MODE_IMP};
         8'hE8: d = '{K_INX, MODE_IMP};
         8'hC8: d = '{K_INY, MODE_IMP};
         8'hCA: d = '{K_DEX, MODE_IMP};
         8'h88: d = '{K_DEY, MODE_IMP};
         8'h18: d = '{K_CLC, MODE_IMP};
         8'h58: d = '{K_CLI, MODE_IMP};
         8'hB8: d = '{K_CLV, MODE_IMP};
         8'h38: d = '{K_SEC, MODE_IMP};
         8'h78: d = '{K_SEI, MODE_IMP};
         default: d = '{K_NOP, MODE_IMP};
      endcase
      return d;
   endfunction

endpackage

@@ hw/rtl/c6502_alu.sv @@
`timescale 1ns / 1ps
module c6502_alu (
   input  c6502_pkg::alu_op_type op,
   input  logic [15:0]           a,
   input  logic [7:0]            b,
   input  logic                  carry_in,
   output logic [15:0]           res,
   output logic                  carry_out,
   output logic                  ovf
);
   import c6502_pkg::*;

   logic [8:0] sum8;

   always_comb begin
      sum8 = 9'd0;
      res = a;
      carry_out = 1'b0;
      ovf = 1'b0;
      case (op)
         ALU_ADC: begin
            sum8 = {1'b0, a[7:0]} + {1'b0, b} + {8'd0, carry_in};
            res = {8'd0, sum8[7:0]};
            carry_out = sum8[8];
            ovf = ~(a[7] ^ b[7]) & (a[7] ^ sum8[7]);
         end
         ALU_INC: res = {8'd0, a[7:0] + 8'd1};
         ALU_DEC: res = {8'd0, a[7:0] - 8'd1};
         // address add: 16-bit base plus zero-extended byte
         ALU_ADD: res = a + {8'd0, b};
         default: res = a;
      endcase
   end
endmodule

@@ hw/rtl/cpu6502_subset_core.sv @@
`timescale 1ns / 1ps
// one item at a time, each a sequence of states with at most one access to the
// single-port memory per cycle, ending with a halt-byte check
// a new item is accepted only after the previous result has been taken
// synchronous reset clears the cpu registers and flags and sets sp to SP_RESET,
// then a clearing pass zeroes every memory byte, during which no item is accepted
module cpu6502_subset_core #(
   parameter int MEM_DEPTH = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_mem_addr,
   input  logic [7:0]  req_mem_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_mem_rdata,
   output logic [7:0]  rsp_reg_acc,
   output logic [7:0]  rsp_reg_xi,
   output logic [7:0]  rsp_reg_yi,
   output logic [7:0]  rsp_stack_ptr,
   output logic [15:0] rsp_prog_counter,
   output logic [7:0]  rsp_status_flags,
   output logic        rsp_halted
);
   import c6502_pkg::*;

   localparam int AW = $clog2(MEM_DEPTH);

   logic [7:0] mem [MEM_DEPTH];

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [1:0] func_ff, func_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0] wdata_ff, wdata_in;
   logic [7:0] a_ff, a_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in;
   logic [15:0] pc_ff, pc_in;
   logic fn_ff, fn_in, fv_ff, fv_in, fi_ff, fi_in, fz_ff, fz_in, fc_ff, fc_in;
   decode_type dec_ff, dec_in;
   logic [7:0] o1_ff, o1_in;
   logic [15:0] ea_ff, ea_in;
   logic [7:0] rdata_ff, rdata_in;
   logic halted_ff, halted_in;
   logic rvalid_ff, rvalid_in;

   // memory port
   logic        me;
   logic        mwe;
   logic [15:0] maddr;
   logic [7:0]  mwd;
   logic [7:0]  mq;

   // shared alu
   alu_op_type  aop;
   logic [15:0] aa, ares;
   logic [7:0]  ab;
   logic        acout, aovf;

   c6502_alu u_alu (
      .op(aop), .a(aa), .b(ab), .carry_in(fc_ff),
      .res(ares), .carry_out(acout), .ovf(aovf)
   );

   always_ff @(posedge clock) begin
      if (me) begin
         if (mwe) begin
            mem[maddr[AW-1:0]] <= mwd;
         end
         mq <= mem[maddr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         a_ff <= '0; x_ff <= '0; y_ff <= '0; sp_ff <= SP_RESET; pc_ff <= '0;
         fn_ff <= 1'b0; fv_ff <= 1'b0; fi_ff <= 1'b0; fz_ff <= 1'b0; fc_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         a_ff <= a_in; x_ff <= x_in; y_ff <= y_in; sp_ff <= sp_in; pc_ff <= pc_in;
         fn_ff <= fn_in; fv_ff <= fv_in; fi_ff <= fi_in; fz_ff <= fz_in;
         fc_ff <= fc_in;
         rvalid_ff <= rvalid_in;
      end
      func_ff <= func_in; addr_ff <= addr_in; wdata_ff <= wdata_in;
      dec_ff <= dec_in; o1_ff <= o1_in; ea_ff <= ea_in;
      rdata_ff <= rdata_in; halted_ff <= halted_in;
   end

   logic is_store, is_rmw;
   logic [7:0] nzv;
   logic nz_set;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      func_in = func_ff; addr_in = addr_ff; wdata_in = wdata_ff;
      a_in = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff; pc_in = pc_ff;
      fn_in = fn_ff; fv_in = fv_ff; fi_in = fi_ff; fz_in = fz_ff; fc_in = fc_ff;
      dec_in = dec_ff; o1_in = o1_ff; ea_in = ea_ff;
      rdata_in = rdata_ff; halted_in = halted_ff; rvalid_in = rvalid_ff;
      me = 1'b0; mwe = 1'b0; maddr = pc_ff; mwd = 8'd0;
      aop = ALU_PASS; aa = 16'd0; ab = 8'd0;
      nzv = 8'd0; nz_set = 1'b0;
      req_ready = 1'b0;
      is_store = dec_ff.kind == K_STA || dec_ff.kind == K_STX || dec_ff.kind == K_STY;
      is_rmw = dec_ff.kind == K_INC || dec_ff.kind == K_DEC;

      unique case (state_ff)
         S_CLEAR: begin
            me = 1'b1; mwe = 1'b1; maddr = 16'(clr_ff); mwd = 8'd0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MEM_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = !rvalid_ff;
            if (req_valid && req_ready) begin
               func_in = req_func; addr_in = req_mem_addr; wdata_in = req_mem_wdata;
               rdata_in = 8'd0;
               state_in = S_ACCESS;
            end
         end
         S_ACCESS: begin
            if (func_ff == FUNC_WRITE) begin
               me = 1'b1; mwe = 1'b1; maddr = addr_ff; mwd = wdata_ff;
               state_in = S_HALTCHK;
            end else if (func_ff == FUNC_READ) begin
               me = 1'b1; maddr = addr_ff;
               state_in = S_DATA;
            end else if (func_ff == FUNC_EXEC) begin
               me = 1'b1; maddr = pc_ff;
               state_in = S_OP;
            end else begin
               state_in = S_HALTCHK;
            end
         end
         S_OP: begin
            if (func_ff == FUNC_READ) begin
               // read item: mq holds the requested byte
               rdata_in = mq;
               state_in = S_HALTCHK;
            end else if (mq == HALT_BYTE) begin
               state_in = S_HALTCHK;
            end else begin
               dec_in = decode(mq);
               if (decode(mq).mode == MODE_IMP) begin
                  state_in = S_WRITE;
               end else begin
                  aop = ALU_ADD; aa = pc_ff; ab = 8'd1;
                  me = 1'b1; maddr = ares;
                  state_in = S_O1;
               end
            end
         end
         S_O1: begin
            o1_in = mq;
            unique case (dec_ff.mode)
               MODE_IMM: begin
                  aop = ALU_ADD; aa = pc_ff; ab = 8'd1;
                  ea_in = ares; state_in = S_WRITE;
                  if (!is_store) begin me = 1'b1; maddr = ares; state_in = S_DATA; end
               end
               MODE_ZP: begin
                  ea_in = {8'd0, mq}; state_in = S_WRITE;
                  if (!is_store) begin me = 1'b1; maddr = {8'd0, mq}; state_in = S_DATA; end
               end
               MODE_ZPX, MODE_ZPY, MODE_INX: begin
                  aop = ALU_ADD; aa = {8'd0, mq};
                  ab = (dec_ff.mode == MODE_ZPY) ? y_ff : x_ff;
                  ea_in = {8'd0, ares[7:0]};
                  if (dec_ff.mode == MODE_INX) begin
                     me = 1'b1; maddr = {8'd0, ares[7:0]}; o1_in = ares[7:0];
                     state_in = S_P1;
                  end else begin
                     state_in = S_WRITE;
                     if (!is_store) begin
                        me = 1'b1; maddr = {8'd0, ares[7:0]}; state_in = S_DATA;
                     end
                  end
               end
               MODE_INY: begin
                  me = 1'b1; maddr = {8'd0, mq}; state_in = S_P1;
               end
               default: begin
                  aop = ALU_ADD; aa = pc_ff; ab = 8'd2;
                  me = 1'b1; maddr = ares; state_in = S_O2;
               end
            endcase
         end
         S_O2: begin
            aop = ALU_ADD; aa = {mq, o1_ff};
            ab = (dec_ff.mode == MODE_ABX) ? x_ff :
                 (dec_ff.mode == MODE_ABY) ? y_ff : 8'd0;
            ea_in = ares; state_in = S_WRITE;
            if (!is_store) begin me = 1'b1; maddr = ares; state_in = S_DATA; end
         end
         S_P1: begin
            // low pointer byte in mq, fetch high with zero-page wrap
            ea_in = {8'd0, mq};
            aop = ALU_ADD; aa = {8'd0, o1_ff}; ab = 8'd1;
            me = 1'b1; maddr = {8'd0, ares[7:0]};
            state_in = S_P2;
         end
         S_P2: begin
            aop = ALU_ADD; aa = {mq, ea_ff[7:0]};
            ab = (dec_ff.mode == MODE_INY) ? y_ff : 8'd0;
            ea_in = ares; state_in = S_WRITE;
            if (!is_store) begin me = 1'b1; maddr = ares; state_in = S_DATA; end
         end
         S_DATA: begin
            if (func_ff == FUNC_READ) begin
               state_in = S_OP;
            end else begin
               rdata_in = 8'd0;
               state_in = S_WRITE;
               unique case (dec_ff.kind)
                  K_LDA: begin a_in = mq; nzv = mq; nz_set = 1'b1; end
                  K_LDX: begin x_in = mq; nzv = mq; nz_set = 1'b1; end
                  K_LDY: begin y_in = mq; nzv = mq; nz_set = 1'b1; end
                  K_ADC: begin
                     aop = ALU_ADC; aa = {8'd0, a_ff}; ab = mq;
                     a_in = ares[7:0]; fc_in = acout; fv_in = aovf;
                     nzv = ares[7:0]; nz_set = 1'b1;
                  end
                  default: begin
                     aop = (dec_ff.kind == K_INC) ? ALU_INC : ALU_DEC; aa = {8'd0, mq};
                     wdata_in = ares[7:0]; nzv = ares[7:0]; nz_set = 1'b1;
                  end
               endcase
            end
         end
         S_WRITE: begin
            // final step of an instruction: store, register ops, pc advance
            aop = ALU_ADD; aa = pc_ff;
            ab = (dec_ff.mode == MODE_IMP) ? 8'd1 :
                 (dec_ff.mode == MODE_ABS || dec_ff.mode == MODE_ABX
                  || dec_ff.mode == MODE_ABY) ? 8'd3 : 8'd2;
            pc_in = ares;
            if (is_store || is_rmw) begin
               me = 1'b1; mwe = 1'b1; maddr = ea_ff;
               mwd = (dec_ff.kind == K_STA) ? a_ff :
                     (dec_ff.kind == K_STX) ? x_ff :
                     (dec_ff.kind == K_STY) ? y_ff : wdata_ff;
            end
            unique case (dec_ff.kind)
               K_TAX: begin x_in = a_ff; nzv = a_ff; nz_set = 1'b1; end
               K_TAY: begin y_in = a_ff; nzv = a_ff; nz_set = 1'b1; end
               K_TXA: begin a_in = x_ff; nzv = x_ff; nz_set = 1'b1; end
               K_TYA: begin a_in = y_ff; nzv = y_ff; nz_set = 1'b1; end
               K_TXS: sp_in = x_ff;
               K_TSX: begin x_in = sp_ff; nzv = sp_ff; nz_set = 1'b1; end
               K_PHA: begin
                  me = 1'b1; mwe = 1'b1; maddr = {STACK_PAGE, sp_ff}; mwd = a_ff;
                  sp_in = sp_ff - 8'd1;
               end
               K_INX: begin x_in = x_ff + 8'd1; nzv = x_in; nz_set = 1'b1; end
               K_INY: begin y_in = y_ff + 8'd1; nzv = y_in; nz_set = 1'b1; end
               K_DEX: begin x_in = x_ff - 8'd1; nzv = x_in; nz_set = 1'b1; end
               K_DEY: begin y_in = y_ff - 8'd1; nzv = y_in; nz_set = 1'b1; end
               K_CLC: fc_in = 1'b0;
               K_CLI: fi_in = 1'b0;
               K_CLV: fv_in = 1'b0;
               K_SEC: fc_in = 1'b1;
               K_SEI: fi_in = 1'b1;
               default: ;
            endcase
            state_in = S_HALTCHK;
         end
         S_HALTCHK: begin
            me = 1'b1; maddr = pc_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            halted_in = (mq == HALT_BYTE);
            rvalid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (nz_set) begin
         fn_in = nzv[7];
         fz_in = (nzv == 8'd0);
      end
      if (rvalid_ff && rsp_ready) begin
         rvalid_in = 1'b0;
      end
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_mem_rdata = rdata_ff;
   assign rsp_reg_acc = a_ff;
   assign rsp_reg_xi = x_ff;
   assign rsp_reg_yi = y_ff;
   assign rsp_stack_ptr = sp_ff;
   assign rsp_prog_counter = pc_ff;
   assign rsp_status_flags = {fn_ff, fv_ff, 1'b1, 1'b0, 1'b0, fi_ff, fz_ff, fc_ff};
   assign rsp_halted = halted_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("ready while busy");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
   a_idle_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (state_ff == S_IDLE && rsp_valid))
      else $error("result not raised");
`endif
endmodule

@@ verif/cpu6502_subset_core_tb.sv @@
`timescale 1ns / 1ps
module cpu6502_subset_core_tb;
   import c6502_pkg::*;

   typedef struct {
      func_type    func;
      logic [15:0] addr;
      logic [7:0]  wdata;
   } req_item_type;

   typedef struct {
      logic [7:0]  rdata;
      logic [7:0]  acc;
      logic [7:0]  xr;
      logic [7:0]  yr;
      logic [7:0]  sp;
      logic [15:0] pc;
      logic [7:0]  flags;
      logic        halted;
   } cpu_view_type;

   localparam logic [7:0] FLAG_C = 8'h01;
   localparam logic [7:0] FLAG_Z = 8'h02;
   localparam logic [7:0] FLAG_I = 8'h04;
   localparam logic [7:0] FLAG_V = 8'h40;
   localparam logic [7:0] FLAG_N = 8'h80;
   localparam logic [7:0] FLAG_ONE = 8'h20;

   localparam int NUM_OPS = 61;
   localparam logic [7:0] OPCODES [NUM_OPS] = '{
      8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1, 8'hA2, 8'hA6,
      8'hB6, 8'hAE, 8'hBE, 8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC, 8'h85, 8'h95,
      8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91, 8'h86, 8'h96, 8'h8E, 8'h84, 8'h94,
      8'h8C, 8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71, 8'hE6,
      8'hF6, 8'hEE, 8'hFE, 8'hDE, 8'hAA, 8'hA8, 8'h8A, 8'h98, 8'h9A, 8'hBA,
      8'h48, 8'hE8, 8'hC8, 8'hCA, 8'h88, 8'h18, 8'h58, 8'hB8, 8'h38, 8'h78,
      8'hFF
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_func;
   logic [15:0] req_mem_addr;
   logic [7:0]  req_mem_wdata;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_mem_rdata;
   logic [7:0]  rsp_reg_acc;
   logic [7:0]  rsp_reg_xi;
   logic [7:0]  rsp_reg_yi;
   logic [7:0]  rsp_stack_ptr;
   logic [15:0] rsp_prog_counter;
   logic [7:0]  rsp_status_flags;
   logic        rsp_halted;

   // shadow of the cpu
   logic [7:0]  mem_img [0:65535];
   logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
   logic [15:0] cpu_pc;

   req_item_type stim_q [$];
   cpu_view_type expected_q [$];
   int          fail_count;
   int          drv_gap, mon_gap;
   bit          drv_quiet, mon_quiet;

   cpu6502_subset_core DUT (.*);

   always #4 clock = ~clock;

   function automatic void set_nz(input logic [7:0] v);
      cpu_p = cpu_p & ~(FLAG_N | FLAG_Z);
      if (v == 8'h00) cpu_p = cpu_p | FLAG_Z;
      if (v[7]) cpu_p = cpu_p | FLAG_N;
   endfunction

   function automatic void decode_op(input logic [7:0] op, output kind_type k,
                                     output mode_type m);
      k = K_NOP;
      m = MODE_IMP;
      case (op)
         8'hA9: begin k = K_LDA; m = MODE_IMM; end
         8'hA5: begin k = K_LDA; m = MODE_ZP;  end
         8'hB5: begin k = K_LDA; m = MODE_ZPX; end
         8'hAD: begin k = K_LDA; m = MODE_ABS; end
         8'hBD: begin k = K_LDA; m = MODE_ABX; end
         8'hB9: begin k = K_LDA; m = MODE_ABY; end
         8'hA1: begin k = K_LDA; m = MODE_INX; end
         8'hB1: begin k = K_LDA; m = MODE_INY; end
         8'hA2: begin k = K_LDX; m = MODE_IMM; end
         8'hA6: begin k = K_LDX; m = MODE_ZP;  end
         8'hB6: begin k = K_LDX; m = MODE_ZPY; end
         8'hAE: begin k = K_LDX; m = MODE_ABS; end
         8'hBE: begin k = K_LDX; m = MODE_ABY; end
         8'hA0: begin k = K_LDY; m = MODE_IMM; end
         8'hA4: begin k = K_LDY; m = MODE_ZP;  end
         8'hB4: begin k = K_LDY; m = MODE_ZPX; end
         8'hAC: begin k = K_LDY; m = MODE_ABS; end
         8'hBC: begin k = K_LDY; m = MODE_ABX; end
         8'h85: begin k = K_STA; m = MODE_ZP;  end
         8'h95: begin k = K_STA; m = MODE_ZPX; end
         8'h8D: begin k = K_STA; m = MODE_ABS; end
         8'h9D: begin k = K_STA; m = MODE_ABX; end
         8'h99: begin k = K_STA; m = MODE_ABY; end
         8'h81: begin k = K_STA; m = MODE_INX; end
         8'h91: begin k = K_STA; m = MODE_INY; end
         8'h86: begin k = K_STX; m = MODE_ZP;  end
         8'h96: begin k = K_STX; m = MODE_ZPY; end
         8'h8E: begin k = K_STX; m = MODE_ABS; end
         8'h84: begin k = K_STY; m = MODE_ZP;  end
         8'h94: begin k = K_STY; m = MODE_ZPX; end
         8'h8C: begin k = K_STY; m = MODE_ABS; end
         8'h69: begin k = K_ADC; m = MODE_IMM; end
         8'h65: begin k = K_ADC; m = MODE_ZP;  end
         8'h75: begin k = K_ADC; m = MODE_ZPX; end
         8'h6D: begin k = K_ADC; m = MODE_ABS; end
         8'h7D: begin k = K_ADC; m = MODE_ABX; end
         8'h79: begin k = K_ADC; m = MODE_ABY; end
         8'h61: begin k = K_ADC; m = MODE_INX; end
         8'h71: begin k = K_ADC; m = MODE_INY; end
         8'hE6: begin k = K_INC; m = MODE_ZP;  end
         8'hF6: begin k = K_INC; m = MODE_ZPX; end
         8'hEE: begin k = K_INC; m = MODE_ABS; end
         8'hFE: begin k = K_INC; m = MODE_ABX; end
         8'hDE: begin k = K_DEC; m = MODE_ABX; end
         8'hAA: k = K_TAX;
         8'hA8: k = K_TAY;
         8'h8A: k = K_TXA;
         8'h98: k = K_TYA;
         8'h9A: k = K_TXS;
         8'hBA: k = K_TSX;
         8'h48: k = K_PHA;
         8'hE8: k = K_INX;
         8'hC8: k = K_INY;
         8'hCA: k = K_DEX;
         8'h88: k = K_DEY;
         8'h18: k = K_CLC;
         8'h58: k = K_CLI;
         8'hB8: k = K_CLV;
         8'h38: k = K_SEC;
         8'h78: k = K_SEI;
         default: k = K_NOP;
      endcase
   endfunction

   function automatic logic [15:0] operand_addr(input mode_type m, output logic [15:0] len);
      logic [7:0]  o1, o2, ptr, ptr_hi;
      logic [15:0] base;
      o1 = mem_img[16'(cpu_pc + 16'd1)];
      o2 = mem_img[16'(cpu_pc + 16'd2)];
      base = {o2, o1};
      len = 16'd2;
      ptr = o1;
      if (m == MODE_INX) ptr = 8'(o1 + cpu_x);
      ptr_hi = 8'(ptr + 8'd1);
      case (m)
         MODE_IMM: return 16'(cpu_pc + 16'd1);
         MODE_ZP:  return {8'h00, o1};
         MODE_ZPX: return {8'h00, 8'(o1 + cpu_x)};
         MODE_ZPY: return {8'h00, 8'(o1 + cpu_y)};
         MODE_ABS: begin len = 16'd3; return base; end
         MODE_ABX: begin len = 16'd3; return 16'(base + cpu_x); end
         MODE_ABY: begin len = 16'd3; return 16'(base + cpu_y); end
         MODE_INX: return {mem_img[{8'h00, ptr_hi}], mem_img[{8'h00, ptr}]};
         default:  return 16'({mem_img[{8'h00, ptr_hi}], mem_img[{8'h00, ptr}]} + cpu_y);
      endcase
   endfunction

   function automatic void step_cpu();
      kind_type    k;
      mode_type    m;
      logic [15:0] ea, len;
      logic [7:0]  d;
      logic [8:0]  sum;
      if (mem_img[cpu_pc] == HALT_BYTE) return;
      decode_op(mem_img[cpu_pc], k, m);
      len = 16'd1;
      ea = 16'h0000;
      if (m != MODE_IMP) ea = operand_addr(m, len);
      d = mem_img[ea];
      case (k)
         K_LDA: begin cpu_a = d; set_nz(d); end
         K_LDX: begin cpu_x = d; set_nz(d); end
         K_LDY: begin cpu_y = d; set_nz(d); end
         K_STA: mem_img[ea] = cpu_a;
         K_STX: mem_img[ea] = cpu_x;
         K_STY: mem_img[ea] = cpu_y;
         K_ADC: begin
            sum = {1'b0, cpu_a} + {1'b0, d} + {8'h00, cpu_p[0]};
            cpu_p = cpu_p & ~(FLAG_C | FLAG_V);
            if (sum[8]) cpu_p = cpu_p | FLAG_C;
            if (~(cpu_a[7] ^ d[7]) & (cpu_a[7] ^ sum[7])) cpu_p = cpu_p | FLAG_V;
            cpu_a = sum[7:0];
            set_nz(cpu_a);
         end
         K_INC: begin mem_img[ea] = 8'(d + 8'd1); set_nz(mem_img[ea]); end
         K_DEC: begin mem_img[ea] = 8'(d - 8'd1); set_nz(mem_img[ea]); end
         K_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
         K_TAY: begin cpu_y = cpu_a; set_nz(cpu_y); end
         K_TXA: begin cpu_a = cpu_x; set_nz(cpu_a); end
         K_TYA: begin cpu_a = cpu_y; set_nz(cpu_a); end
         K_TXS: cpu_sp = cpu_x;
         K_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
         K_PHA: begin mem_img[{STACK_PAGE, cpu_sp}] = cpu_a; cpu_sp = 8'(cpu_sp - 8'd1); end
         K_INX: begin cpu_x = 8'(cpu_x + 8'd1); set_nz(cpu_x); end
         K_INY: begin cpu_y = 8'(cpu_y + 8'd1); set_nz(cpu_y); end
         K_DEX: begin cpu_x = 8'(cpu_x - 8'd1); set_nz(cpu_x); end
         K_DEY: begin cpu_y = 8'(cpu_y - 8'd1); set_nz(cpu_y); end
         K_CLC: cpu_p = cpu_p & ~FLAG_C;
         K_CLI: cpu_p = cpu_p & ~FLAG_I;
         K_CLV: cpu_p = cpu_p & ~FLAG_V;
         K_SEC: cpu_p = cpu_p | FLAG_C;
         K_SEI: cpu_p = cpu_p | FLAG_I;
         default: ;
      endcase
      cpu_pc = 16'(cpu_pc + len);
   endfunction

   // queue one item and the cpu view it should leave behind
   function automatic void send_item(input func_type f, input logic [15:0] addr,
                                     input logic [7:0] wdata);
      req_item_type it;
      cpu_view_type v;
      it = '{func: f, addr: addr, wdata: wdata};
      v.rdata = 8'h00;
      case (f)
         FUNC_WRITE: mem_img[addr] = wdata;
         FUNC_READ:  v.rdata = mem_img[addr];
         FUNC_EXEC:  step_cpu();
         default: ;
      endcase
      v.acc = cpu_a;
      v.xr = cpu_x;
      v.yr = cpu_y;
      v.sp = cpu_sp;
      v.pc = cpu_pc;
      v.flags = cpu_p | FLAG_ONE;
      v.halted = (mem_img[cpu_pc] == HALT_BYTE);
      stim_q.push_back(it);
      expected_q.push_back(v);
   endfunction

   // place an instruction at the program counter and run it
   function automatic void run_instr(input logic [7:0] op, input logic [7:0] o1,
                                     input logic [7:0] o2);
      logic [15:0] pc0;
      pc0 = cpu_pc;
      send_item(FUNC_WRITE, pc0, op);
      send_item(FUNC_WRITE, 16'(pc0 + 16'd1), o1);
      send_item(FUNC_WRITE, 16'(pc0 + 16'd2), o2);
      send_item(FUNC_EXEC, 16'($urandom), 8'($urandom));
   endfunction

   function automatic void check_field(input string name, input logic [15:0] exp_v,
                                       input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // request side
   always @(posedge clock) begin
      req_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         drv_gap <= 0;
      end else if (req_valid && !req_ready) begin
         // hold the item until it is taken
      end else if (drv_gap != 0) begin
         req_valid <= 1'b0;
         drv_gap <= drv_gap - 1;
      end else if (stim_q.size() > 0) begin
         it = stim_q.pop_front();
         req_func <= it.func;
         req_mem_addr <= it.addr;
         req_mem_wdata <= it.wdata;
         req_valid <= 1'b1;
         if ($urandom_range(0, 15) == 0) drv_quiet = !drv_quiet;
         drv_gap <= drv_quiet ? 0 : $urandom_range(0, 5);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // response side
   always @(posedge clock) begin
      cpu_view_type v;
      int gap;
      if (reset) begin
         rsp_ready <= 1'b0;
         mon_gap <= 0;
      end else begin
         gap = mon_gap;
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected item, expected none got pc %h", $time,
                        rsp_prog_counter);
               fail_count++;
            end else begin
               v = expected_q.pop_front();
               check_field("mem_rdata", v.rdata, rsp_mem_rdata);
               check_field("reg_acc", v.acc, rsp_reg_acc);
               check_field("reg_xi", v.xr, rsp_reg_xi);
               check_field("reg_yi", v.yr, rsp_reg_yi);
               check_field("stack_ptr", v.sp, rsp_stack_ptr);
               check_field("prog_counter", v.pc, rsp_prog_counter);
               check_field("status_flags", v.flags, rsp_status_flags);
               check_field("halted", v.halted, rsp_halted);
            end
            if ($urandom_range(0, 15) == 0) mon_quiet = !mon_quiet;
            gap = mon_quiet ? 0 : $urandom_range(0, 5);
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            mon_gap <= gap - 1;
         end else begin
            rsp_ready <= 1'b1;
            mon_gap <= 0;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("cpu6502_subset_core: mismatch");
      $finish;
   end

   initial begin
      int pick;
      logic [7:0] o1;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      req_func = FUNC_NONE;
      req_mem_addr = 16'h0000;
      req_mem_wdata = 8'h00;
      fail_count = 0;
      drv_quiet = 1'b0;
      mon_quiet = 1'b0;
      foreach (mem_img[i]) mem_img[i] = 8'h00;
      cpu_a = 8'h00;
      cpu_x = 8'h00;
      cpu_y = 8'h00;
      cpu_sp = SP_RESET;
      cpu_pc = 16'h0000;
      cpu_p = 8'h00;

      // directed: field extremes, flags, wraps, stack and halt
      send_item(FUNC_WRITE, 16'hFFFF, 8'hFF);
      send_item(FUNC_READ, 16'hFFFF, 8'h00);
      send_item(FUNC_READ, 16'h0000, 8'hFF);
      send_item(FUNC_NONE, 16'hA5A5, 8'h5A);
      run_instr(8'hA9, 8'h50, 8'h00);   // lda #$50
      run_instr(8'h69, 8'h50, 8'h00);   // signed overflow
      run_instr(8'h69, 8'h60, 8'h00);   // carry out, zero
      run_instr(8'hA2, 8'hFF, 8'h00);   // x = ff
      run_instr(8'hB5, 8'h80, 8'h00);   // zero-page index wraps
      run_instr(8'hDE, 8'hFF, 8'hFF);   // dec abs,x wraps at 16 bits
      run_instr(8'hA2, 8'h00, 8'h00);
      run_instr(8'h9A, 8'h00, 8'h00);   // txs with x = 0
      run_instr(8'h48, 8'h00, 8'h00);   // push, sp wraps to ff
      run_instr(8'hBA, 8'h00, 8'h00);
      run_instr(8'h38, 8'h00, 8'h00);
      run_instr(8'hFF, 8'h00, 8'h00);   // halt
      send_item(FUNC_EXEC, 16'h0000, 8'h00);

      while (stim_q.size() < 1700) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            o1 = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            // seed pointer and data bytes in the zero page
            if ($urandom_range(0, 1) == 0)
               send_item(FUNC_WRITE, {8'h00, 8'(o1 + cpu_x + $urandom_range(0, 1))},
                         8'($urandom));
            if ($urandom_range(0, 2) == 0)
               send_item(FUNC_WRITE, {8'h00, 8'(o1 + $urandom_range(0, 1))},
                         8'($urandom));
            run_instr(($urandom_range(0, 19) == 0) ? 8'($urandom) :
                      OPCODES[$urandom_range(0, NUM_OPS - 1)], o1, 8'($urandom));
            if (mem_img[cpu_pc] == HALT_BYTE)
               send_item(FUNC_EXEC, 16'($urandom), 8'($urandom));
         end else if (pick < 85) begin
            send_item(FUNC_WRITE, 16'($urandom), 8'($urandom));
         end else if (pick < 95) begin
            case ($urandom_range(0, 2))
               0: send_item(FUNC_READ, 16'($urandom), 8'($urandom));
               1: send_item(FUNC_READ, {8'h00, 8'($urandom)}, 8'($urandom));
               default: send_item(FUNC_READ, {STACK_PAGE, 8'(cpu_sp + 8'd1)}, 8'($urandom));
            endcase
         end else begin
            send_item(FUNC_NONE, 16'($urandom), 8'($urandom));
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (stim_q.size() != 0 || expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("cpu6502_subset_core: match");
      end else begin
         $display("cpu6502_subset_core: mismatch");
      end
      $finish;
   end

endmodule
